// ----- hw/rtl/ddge_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the dirty dependency graph engine.
// Command and status codes and parameter defaults; no dependencies.
package ddge_pkg;

    localparam int NODE_SLOTS_DEF = 32;
    localparam int ID_BITS_DEF    = 16;
    localparam int KIND_BITS_DEF  = 4;

    localparam int CMD_W = 4;
    localparam int ST_W  = 2;

    localparam logic [CMD_W-1:0] CMD_ADD        = 4'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 4'd1;
    localparam logic [CMD_W-1:0] CMD_CONNECT    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DISCONNECT = 4'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 4'd4;
    localparam logic [CMD_W-1:0] CMD_MARK_DIRTY = 4'd5;
    localparam logic [CMD_W-1:0] CMD_CLR_DIRTY  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd7;
    localparam logic [CMD_W-1:0] CMD_CYCLE_CHK  = 4'd8;
    localparam logic [CMD_W-1:0] CMD_EVALUATE   = 4'd9;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_REJECT = 2'd1;
    localparam logic [ST_W-1:0] ST_CYCLE  = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

endpackage

// ----- hw/rtl/dirty_dependency_graph_engine_unit.sv -----
`timescale 1ns / 1ps
// Dirty dependency graph engine: slot table, adjacency matrix and command sequencer.
// Depends on ddge_pkg for command/status codes and parameter defaults.

// One command beat is taken when s_axis_tready is high, which it is only while the
// sequencer is idle. Every command first scans the slot table, one slot a cycle,
// with one id comparator per operand. Edits, queries and clears then execute in
// S_EXEC and report from S_DONE. Mark dirty repeats a sweep, one adjacency row a
// cycle, until the reachable set stops growing (at most NODE_SLOTS+1 sweeps). Cycle
// check and evaluate run Kahn's sort on the same slot walk: an in-degree sweep, then
// for each node a minimum-id search and an update step. Evaluate runs the sort
// twice: once to rule out a cycle, then again streaming one beat per node in
// ascending ready-id order, with tlast on the final one. A cycle gives a single beat
// with status 2. The result register frees the input side as soon as a beat is
// loaded.
module dirty_dependency_graph_engine_unit #(
    parameter int NODE_SLOTS = ddge_pkg::NODE_SLOTS_DEF,
    parameter int ID_BITS    = ddge_pkg::ID_BITS_DEF,
    parameter int KIND_BITS  = ddge_pkg::KIND_BITS_DEF,
    localparam int CNT_W     = $clog2(NODE_SLOTS + 1),
    localparam int IN_RAW_W  = ddge_pkg::CMD_W + 3 * ID_BITS + KIND_BITS,
    localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8,
    localparam int OUT_RAW_W = ddge_pkg::ST_W + ID_BITS + 1 + KIND_BITS + 1 + CNT_W,
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // command, node_id, src_id, dst_id, node_kind (lowest first), zero pad
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // status, result_id, present, kind_out, dirty_out, node_total (lowest first), zero pad
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic             m_axis_tlast
);

    localparam int IDX_W = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int DEG_W = $clog2(NODE_SLOTS + 1);
    localparam int CW    = ddge_pkg::CMD_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_SLOTS - 1);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SCAN = 9'b000000010,
        S_EXEC = 9'b000000100,
        S_GROW = 9'b000001000,
        S_DEG  = 9'b000010000,
        S_SEL  = 9'b000100000,
        S_EMIT = 9'b001000000,
        S_UPD  = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state r_state;

    // slot table and adjacency (row s, bit d = edge s -> d)
    logic [NODE_SLOTS-1:0] r_valid;
    logic [NODE_SLOTS-1:0] r_dirty;
    logic [ID_BITS-1:0]    r_id   [NODE_SLOTS];
    logic [KIND_BITS-1:0]  r_kind [NODE_SLOTS];
    logic [NODE_SLOTS-1:0] r_row  [NODE_SLOTS];
    logic [DEG_W-1:0]      r_indeg[NODE_SLOTS];
    logic [NODE_SLOTS-1:0] r_work;
    logic [NODE_SLOTS-1:0] r_reach;
    logic [ID_BITS-1:0]    r_next_id;
    logic [CNT_W-1:0]      r_count;

    // latched command
    logic [CW-1:0]        r_cmd;
    logic [ID_BITS-1:0]   r_nid, r_src, r_dst;
    logic [KIND_BITS-1:0] r_kin;

    // scan results
    logic [IDX_W-1:0] r_idx, r_hit_n, r_hit_s, r_hit_d, r_free, r_best;
    logic             r_fn, r_fs, r_fd, r_ff, r_found, r_changed, r_pass;
    logic [ID_BITS-1:0] r_best_id;

    // pending single result
    logic [ddge_pkg::ST_W-1:0] r_res_st;
    logic [ID_BITS-1:0]        r_res_id;
    logic                      r_res_pres, r_res_dirty;
    logic [KIND_BITS-1:0]      r_res_kind;

    // output register
    logic                      r_out_valid, r_out_last, r_out_pres, r_out_dirty;
    logic [ddge_pkg::ST_W-1:0] r_out_st;
    logic [ID_BITS-1:0]        r_out_id;
    logic [KIND_BITS-1:0]      r_out_kind;
    logic [CNT_W-1:0]          r_out_cnt;

    logic                  in_acc, out_free, last_idx;
    logic [NODE_SLOTS-1:0] best_bit, work_left, grow_new;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;
    assign last_idx  = (r_idx == LAST_IDX);
    assign best_bit  = NODE_SLOTS'(1) << r_best;
    assign work_left = r_work & ~best_bit;
    assign grow_new  = r_reach[r_idx] ? (r_row[r_idx] & ~r_reach) : '0;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = OUT_W'({r_out_cnt, r_out_dirty, r_out_kind, r_out_pres,
                                   r_out_id, r_out_st});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_work      <= '0;
            r_next_id   <= ID_BITS'(1);
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NODE_SLOTS; i++) begin
                r_row[i]   <= '0;
                r_indeg[i] <= '0;
            end
        end else begin
            // drop the beat once taken
            if (r_out_valid && m_axis_tready)
                r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd <= s_axis_tdata[CW-1:0];
                        r_nid <= s_axis_tdata[CW +: ID_BITS];
                        r_src <= s_axis_tdata[CW+ID_BITS +: ID_BITS];
                        r_dst <= s_axis_tdata[CW+2*ID_BITS +: ID_BITS];
                        r_kin <= s_axis_tdata[CW+3*ID_BITS +: KIND_BITS];
                        r_idx <= '0;
                        r_fn  <= 1'b0;
                        r_fs  <= 1'b0;
                        r_fd  <= 1'b0;
                        r_ff  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end

                // one slot a cycle: locate operands and the lowest free slot
                S_SCAN: begin
                    if (r_valid[r_idx]) begin
                        if (r_id[r_idx] == r_nid) begin r_fn <= 1'b1; r_hit_n <= r_idx; end
                        if (r_id[r_idx] == r_src) begin r_fs <= 1'b1; r_hit_s <= r_idx; end
                        if (r_id[r_idx] == r_dst) begin r_fd <= 1'b1; r_hit_d <= r_idx; end
                    end else if (!r_ff) begin
                        r_ff   <= 1'b1;
                        r_free <= r_idx;
                    end
                    r_idx <= r_idx + IDX_W'(1);
                    if (last_idx)
                        r_state <= S_EXEC;
                end

                S_EXEC: begin
                    r_res_st    <= ddge_pkg::ST_OK;
                    r_res_id    <= '0;
                    r_res_pres  <= 1'b0;
                    r_res_kind  <= '0;
                    r_res_dirty <= 1'b0;
                    r_state     <= S_DONE;
                    case (r_cmd)
                        ddge_pkg::CMD_ADD: begin
                            if (!r_ff || r_next_id == '0) begin
                                r_res_st <= ddge_pkg::ST_FULL;
                            end else begin
                                r_valid[r_free] <= 1'b1;
                                r_id[r_free]    <= r_next_id;
                                r_kind[r_free]  <= r_kin;
                                r_dirty[r_free] <= 1'b1;
                                for (int i = 0; i < NODE_SLOTS; i++)
                                    r_row[i][r_free] <= 1'b0;
                                r_row[r_free] <= '0;
                                r_next_id <= r_next_id + ID_BITS'(1);
                                r_count   <= r_count + CNT_W'(1);
                                r_res_id  <= r_next_id;
                            end
                        end
                        ddge_pkg::CMD_REMOVE: begin
                            if (!r_fn) begin
                                r_res_st <= ddge_pkg::ST_REJECT;
                            end else begin
                                r_valid[r_hit_n] <= 1'b0;
                                for (int i = 0; i < NODE_SLOTS; i++)
                                    r_row[i][r_hit_n] <= 1'b0;
                                r_row[r_hit_n] <= '0;
                                r_count <= r_count - CNT_W'(1);
                            end
                        end
                        ddge_pkg::CMD_CONNECT, ddge_pkg::CMD_DISCONNECT: begin
                            if (!r_fs || !r_fd || r_hit_s == r_hit_d ||
                                r_row[r_hit_s][r_hit_d] == (r_cmd == ddge_pkg::CMD_CONNECT))
                                r_res_st <= ddge_pkg::ST_REJECT;
                            else
                                r_row[r_hit_s][r_hit_d] <= !r_row[r_hit_s][r_hit_d];
                        end
                        ddge_pkg::CMD_QUERY: begin
                            r_res_id <= r_nid;
                            if (!r_fn) begin
                                r_res_st <= ddge_pkg::ST_REJECT;
                            end else begin
                                r_res_pres  <= 1'b1;
                                r_res_kind  <= r_kind[r_hit_n];
                                r_res_dirty <= r_dirty[r_hit_n];
                            end
                        end
                        ddge_pkg::CMD_MARK_DIRTY: begin
                            if (!r_fn) begin
                                r_res_st <= ddge_pkg::ST_REJECT;
                            end else begin
                                r_reach   <= NODE_SLOTS'(1) << r_hit_n;
                                r_idx     <= '0;
                                r_changed <= 1'b0;
                                r_state   <= S_GROW;
                            end
                        end
                        ddge_pkg::CMD_CLR_DIRTY: r_dirty <= '0;
                        ddge_pkg::CMD_CLEAR: begin
                            r_valid <= '0;
                            r_count <= '0;
                            for (int i = 0; i < NODE_SLOTS; i++)
                                r_row[i] <= '0;
                        end
                        ddge_pkg::CMD_CYCLE_CHK, ddge_pkg::CMD_EVALUATE: begin
                            r_pass <= 1'b0;
                            r_work <= r_valid;
                            r_idx  <= '0;
                            for (int i = 0; i < NODE_SLOTS; i++)
                                r_indeg[i] <= '0;
                            r_state <= S_DEG;
                        end
                        default: r_res_st <= ddge_pkg::ST_REJECT;
                    endcase
                end

                // widen the reachable set one row a cycle until a sweep adds nothing
                S_GROW: begin
                    r_reach <= r_reach | grow_new;
                    r_idx   <= r_idx + IDX_W'(1);
                    if (grow_new != '0)
                        r_changed <= 1'b1;
                    if (last_idx) begin
                        if (r_changed || grow_new != '0) begin
                            r_changed <= 1'b0;
                            r_idx     <= '0;
                        end else begin
                            r_dirty <= r_dirty | (r_reach & r_valid);
                            r_state <= S_DONE;
                        end
                    end
                end

                // accumulate in-degrees, one source row a cycle
                S_DEG: begin
                    if (r_work[r_idx])
                        for (int i = 0; i < NODE_SLOTS; i++)
                            r_indeg[i] <= r_indeg[i] + DEG_W'(r_row[r_idx][i]);
                    r_idx <= r_idx + IDX_W'(1);
                    if (last_idx) begin
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        if (r_work == '0)
                            r_state <= S_DONE;
                        else
                            r_state <= S_SEL;
                    end
                end

                // smallest-id ready node, one slot a cycle
                S_SEL: begin
                    if (r_work[r_idx] && r_indeg[r_idx] == '0 &&
                        (!r_found || r_id[r_idx] < r_best_id)) begin
                        r_found   <= 1'b1;
                        r_best    <= r_idx;
                        r_best_id <= r_id[r_idx];
                    end
                    r_idx <= r_idx + IDX_W'(1);
                    if (last_idx) begin
                        if (!r_found && !(r_work[r_idx] && r_indeg[r_idx] == '0)) begin
                            r_res_st <= ddge_pkg::ST_CYCLE;
                            r_state  <= S_DONE;
                        end else if (r_pass) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_UPD;
                        end
                    end
                end

                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid     <= 1'b1;
                        r_out_st        <= ddge_pkg::ST_OK;
                        r_out_id        <= r_best_id;
                        r_out_pres      <= 1'b1;
                        r_out_kind      <= '0;
                        r_out_dirty     <= r_dirty[r_best];
                        r_out_cnt       <= r_count;
                        r_out_last      <= (work_left == '0);
                        r_dirty[r_best] <= 1'b0;
                        r_state         <= S_UPD;
                    end
                end

                // retire the chosen node and release its successors
                S_UPD: begin
                    r_work  <= work_left;
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    for (int i = 0; i < NODE_SLOTS; i++)
                        if (r_row[r_best][i] && r_indeg[i] != '0)
                            r_indeg[i] <= r_indeg[i] - DEG_W'(1);
                    if (work_left != '0) begin
                        r_state <= S_SEL;
                    end else if (r_pass) begin
                        r_state <= S_IDLE;
                    end else if (r_cmd == ddge_pkg::CMD_EVALUATE) begin
                        // acyclic: rerun and stream the order
                        r_pass <= 1'b1;
                        r_work <= r_valid;
                        for (int i = 0; i < NODE_SLOTS; i++)
                            r_indeg[i] <= '0;
                        r_state <= S_DEG;
                    end else begin
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_st    <= r_res_st;
                        r_out_id    <= r_res_id;
                        r_out_pres  <= r_res_pres;
                        r_out_kind  <= r_res_kind;
                        r_out_dirty <= r_res_dirty;
                        r_out_cnt   <= r_count;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/ddge_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the dirty dependency graph engine, bound to its top level.
// Depends on ddge_pkg for status codes and parameter defaults.
module ddge_port_props #(
    parameter int NODE_SLOTS = ddge_pkg::NODE_SLOTS_DEF,
    parameter int ID_BITS    = ddge_pkg::ID_BITS_DEF,
    parameter int KIND_BITS  = ddge_pkg::KIND_BITS_DEF,
    localparam int CNT_W     = $clog2(NODE_SLOTS + 1),
    localparam int OUT_RAW_W = ddge_pkg::ST_W + ID_BITS + 1 + KIND_BITS + 1 + CNT_W,
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tlast
);

    localparam int PRES_B = ddge_pkg::ST_W + ID_BITS;
    localparam int CNT_B  = PRES_B + 2 + KIND_BITS;

    logic [ddge_pkg::ST_W-1:0] st;
    logic [ID_BITS-1:0]        rid;
    logic                      pres;
    logic [CNT_W-1:0]          cnt;

    assign st   = m_axis_tdata[ddge_pkg::ST_W-1:0];
    assign rid  = m_axis_tdata[ddge_pkg::ST_W +: ID_BITS];
    assign pres = m_axis_tdata[PRES_B];
    assign cnt  = m_axis_tdata[CNT_B +: CNT_W];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command taken while previous still running");

    a_cycle_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && st == ddge_pkg::ST_CYCLE |-> m_axis_tlast && !pres)
        else $error("cycle status not a lone final beat");

    a_present_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && pres |-> rid != '0 && cnt != '0)
        else $error("present node with id zero or empty table");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> cnt <= CNT_W'(NODE_SLOTS))
        else $error("node total beyond slot count");

endmodule

bind dirty_dependency_graph_engine_unit ddge_port_props #(
    .NODE_SLOTS(NODE_SLOTS),
    .ID_BITS   (ID_BITS),
    .KIND_BITS (KIND_BITS)
) u_ddge_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
);

// ----- dv/ddge_checker.sv -----
`timescale 1ns / 1ps
// Graph engine checker: watches both stream channels, predicts result beats and compares.
// Depends on ddge_pkg for command and status codes.
module ddge_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  logic        i_cmd_ready,
    input  logic [55:0] i_cmd_data,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [31:0] i_res_data,
    input  logic        i_res_last,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int SLOTS  = ddge_pkg::NODE_SLOTS_DEF;
    localparam int QDEPTH = 64;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] id;
        logic        present;
        logic [3:0]  kind;
        logic        dirty;
        logic [5:0]  total;
        logic        last;
    } t_res_beat;

    logic              slot_used  [SLOTS];
    logic [15:0]       slot_id    [SLOTS];
    logic [3:0]        slot_kind  [SLOTS];
    logic              slot_dirty [SLOTS];
    logic [SLOTS-1:0]  edge_row   [SLOTS];
    logic [15:0]       fresh_id;
    int                topo_slot  [SLOTS];
    t_res_beat         exp_mem    [QDEPTH];
    int                wr_cnt, rd_cnt;
    int                fails;

    assign o_fail_count = fails;
    assign o_pending    = wr_cnt - rd_cnt;

    function automatic int find_node(logic [15:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_id[i] == id) return i;
        return -1;
    endfunction

    function automatic int live_nodes();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++) n += slot_used[i];
        return n;
    endfunction

    // Kahn order, smallest ready id first; -1 on a cycle
    function automatic int topo_sort();
        int               deg [SLOTS];
        logic [SLOTS-1:0] open_set;
        int               n, best;
        n = 0;
        for (int i = 0; i < SLOTS; i++) open_set[i] = slot_used[i];
        for (int d = 0; d < SLOTS; d++) begin
            deg[d] = 0;
            for (int s = 0; s < SLOTS; s++)
                if (open_set[s] && edge_row[s][d]) deg[d]++;
        end
        while (open_set != '0) begin
            best = -1;
            for (int i = 0; i < SLOTS; i++)
                if (open_set[i] && deg[i] == 0 && (best < 0 || slot_id[i] < slot_id[best]))
                    best = i;
            if (best < 0) return -1;
            topo_slot[n++] = best;
            open_set[best] = 1'b0;
            for (int i = 0; i < SLOTS; i++)
                if (edge_row[best][i] && deg[i] > 0) deg[i]--;
        end
        return n;
    endfunction

    function automatic void push_beat(logic [1:0] st, logic [15:0] id, logic pr,
                                      logic [3:0] kd, logic dt, logic lst);
        t_res_beat b;
        b.status  = st;
        b.id      = id;
        b.present = pr;
        b.kind    = kd;
        b.dirty   = dt;
        b.total   = 6'(live_nodes());
        b.last    = lst;
        exp_mem[wr_cnt % QDEPTH] = b;
        wr_cnt++;
    endfunction

    function automatic void apply_command(logic [55:0] beat);
        logic [3:0]       cmd;
        logic [15:0]      nid, src, dst;
        logic [3:0]       kind;
        int               s, d, n;
        logic [SLOTS-1:0] reach, grown;
        cmd  = beat[3:0];
        nid  = beat[19:4];
        src  = beat[35:20];
        dst  = beat[51:36];
        kind = beat[55:52];
        case (cmd)
            ddge_pkg::CMD_ADD: begin
                s = -1;
                for (int i = SLOTS - 1; i >= 0; i--) if (!slot_used[i]) s = i;
                if (s < 0 || fresh_id == '0) begin
                    push_beat(ddge_pkg::ST_FULL, '0, 1'b0, '0, 1'b0, 1'b1);
                end else begin
                    slot_used[s]  = 1'b1;
                    slot_id[s]    = fresh_id;
                    slot_kind[s]  = kind;
                    slot_dirty[s] = 1'b1;
                    edge_row[s]   = '0;
                    for (int i = 0; i < SLOTS; i++) edge_row[i][s] = 1'b0;
                    fresh_id++;
                    push_beat(ddge_pkg::ST_OK, slot_id[s], 1'b0, '0, 1'b0, 1'b1);
                end
            end
            ddge_pkg::CMD_REMOVE: begin
                s = find_node(nid);
                if (s < 0) begin
                    push_beat(ddge_pkg::ST_REJECT, '0, 1'b0, '0, 1'b0, 1'b1);
                end else begin
                    slot_used[s] = 1'b0;
                    edge_row[s]  = '0;
                    for (int i = 0; i < SLOTS; i++) edge_row[i][s] = 1'b0;
                    push_beat(ddge_pkg::ST_OK, '0, 1'b0, '0, 1'b0, 1'b1);
                end
            end
            ddge_pkg::CMD_CONNECT, ddge_pkg::CMD_DISCONNECT: begin
                s = find_node(src);
                d = find_node(dst);
                if (s < 0 || d < 0 || s == d ||
                    edge_row[s][d] == (cmd == ddge_pkg::CMD_CONNECT)) begin
                    push_beat(ddge_pkg::ST_REJECT, '0, 1'b0, '0, 1'b0, 1'b1);
                end else begin
                    edge_row[s][d] = ~edge_row[s][d];
                    push_beat(ddge_pkg::ST_OK, '0, 1'b0, '0, 1'b0, 1'b1);
                end
            end
            ddge_pkg::CMD_QUERY: begin
                s = find_node(nid);
                if (s < 0)
                    push_beat(ddge_pkg::ST_REJECT, nid, 1'b0, '0, 1'b0, 1'b1);
                else
                    push_beat(ddge_pkg::ST_OK, nid, 1'b1, slot_kind[s], slot_dirty[s], 1'b1);
            end
            ddge_pkg::CMD_MARK_DIRTY: begin
                s = find_node(nid);
                if (s < 0) begin
                    push_beat(ddge_pkg::ST_REJECT, '0, 1'b0, '0, 1'b0, 1'b1);
                end else begin
                    reach    = '0;
                    reach[s] = 1'b1;
                    forever begin
                        grown = reach;
                        for (int i = 0; i < SLOTS; i++) if (reach[i]) grown |= edge_row[i];
                        if (grown == reach) break;
                        reach = grown;
                    end
                    for (int i = 0; i < SLOTS; i++)
                        if (reach[i] && slot_used[i]) slot_dirty[i] = 1'b1;
                    push_beat(ddge_pkg::ST_OK, '0, 1'b0, '0, 1'b0, 1'b1);
                end
            end
            ddge_pkg::CMD_CLR_DIRTY: begin
                for (int i = 0; i < SLOTS; i++) slot_dirty[i] = 1'b0;
                push_beat(ddge_pkg::ST_OK, '0, 1'b0, '0, 1'b0, 1'b1);
            end
            ddge_pkg::CMD_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) begin
                    slot_used[i] = 1'b0;
                    edge_row[i]  = '0;
                end
                push_beat(ddge_pkg::ST_OK, '0, 1'b0, '0, 1'b0, 1'b1);
            end
            ddge_pkg::CMD_CYCLE_CHK: begin
                n = topo_sort();
                push_beat((n < 0) ? ddge_pkg::ST_CYCLE : ddge_pkg::ST_OK,
                          '0, 1'b0, '0, 1'b0, 1'b1);
            end
            ddge_pkg::CMD_EVALUATE: begin
                n = topo_sort();
                if (n < 0) begin
                    push_beat(ddge_pkg::ST_CYCLE, '0, 1'b0, '0, 1'b0, 1'b1);
                end else if (n == 0) begin
                    push_beat(ddge_pkg::ST_OK, '0, 1'b0, '0, 1'b0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        push_beat(ddge_pkg::ST_OK, slot_id[topo_slot[i]], 1'b1, '0,
                                  slot_dirty[topo_slot[i]], i == n - 1);
                        slot_dirty[topo_slot[i]] = 1'b0;
                    end
                end
            end
            default: push_beat(ddge_pkg::ST_REJECT, '0, 1'b0, '0, 1'b0, 1'b1);
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_res_beat got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_used[i]  = 1'b0;
                slot_id[i]    = '0;
                slot_kind[i]  = '0;
                slot_dirty[i] = 1'b0;
                edge_row[i]   = '0;
            end
            fresh_id = 16'd1;
            wr_cnt   = 0;
            rd_cnt   = 0;
            fails    = 0;
        end else begin
            // check before predicting: a beat cannot answer a command taken this edge
            if (i_res_valid && i_res_ready) begin
                got = {i_res_data[1:0], i_res_data[17:2], i_res_data[18], i_res_data[22:19],
                       i_res_data[23], i_res_data[29:24], i_res_last};
                if (wr_cnt == rd_cnt) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result beat %h", got);
                end else begin
                    want = exp_mem[rd_cnt % QDEPTH];
                    rd_cnt++;
                    if (got != want || i_res_data[31:30] != '0) begin
                        fails++;
                        if (fails <= 10)
                            $display({"mismatch st %0d/%0d id %0d/%0d pr %0d/%0d ",
                                      "kind %0d/%0d dirty %0d/%0d tot %0d/%0d ",
                                      "last %0d/%0d (exp/act)"},
                                     want.status, got.status, want.id, got.id,
                                     want.present, got.present, want.kind, got.kind,
                                     want.dirty, got.dirty, want.total, got.total,
                                     want.last, got.last);
                    end
                end
            end
            if (i_cmd_valid && i_cmd_ready) apply_command(i_cmd_data);
        end
    end
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the graph engine testbench: clock, reset, command stimulus and verdict.
// Depends on ddge_pkg, dirty_dependency_graph_engine_unit and ddge_checker.
module tb_top;

    // codes past evaluate are undefined and must be rejected
    localparam logic [ddge_pkg::CMD_W-1:0] CMD_UNKNOWN_LO = ddge_pkg::CMD_EVALUATE + 4'd1;
    localparam logic [ddge_pkg::CMD_W-1:0] CMD_UNKNOWN_HI = 4'hF;
    localparam int STALL_LIMIT = 30000;
    localparam int RANDOM_CMDS = 420;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    logic [55:0] cmd_data = '0;   // command, node_id, src_id, dst_id, node_kind
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [31:0] res_data;        // status, result_id, present, kind_out, dirty_out, node_total
    logic        res_last;
    int          fail_count, pending;
    int          send_idle_pct = 0, recv_stall_pct = 0;
    int          adds_sent = 0;
    int          quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    dirty_dependency_graph_engine_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(cmd_valid),
        .s_axis_tready(cmd_ready),
        .s_axis_tdata (cmd_data),
        .m_axis_tvalid(res_valid),
        .m_axis_tready(res_ready),
        .m_axis_tdata (res_data),
        .m_axis_tlast (res_last)
    );

    ddge_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .i_cmd_data  (cmd_data),
        .i_res_valid (res_valid),
        .i_res_ready (res_ready),
        .i_res_data  (res_data),
        .i_res_last  (res_last),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Stall the result side at the current phase's rate
    always @(posedge i_clk) begin
        res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: abort if no beat moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Drive one command beat, hold it until taken, then maybe idle a while
    task automatic send_cmd(logic [3:0] cmd, logic [15:0] nid, logic [15:0] src,
                            logic [15:0] dst, logic [3:0] kind);
        cmd_valid <= 1'b1;
        cmd_data  <= {kind, dst, src, nid, cmd};
        @(posedge i_clk);
        while (!cmd_ready) @(posedge i_clk);
        if (cmd == ddge_pkg::CMD_ADD) adds_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            cmd_valid <= 1'b0;
            cmd_data  <= 56'({$urandom, $urandom});
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
    endtask

    // Mostly ids that were handed out recently, so most commands hit live nodes
    function automatic logic [15:0] pick_id();
        int r, lo;
        r  = $urandom_range(99);
        lo = (adds_sent > 36) ? adds_sent - 35 : 1;
        if (r < 85) return 16'($urandom_range(lo, adds_sent + 1));
        if (r < 90) return '0;
        return 16'($urandom);
    endfunction

    task automatic random_cmd();
        int          w;
        logic [3:0]  cmd;
        w = $urandom_range(99);
        if      (w < 20) cmd = ddge_pkg::CMD_ADD;
        else if (w < 27) cmd = ddge_pkg::CMD_REMOVE;
        else if (w < 57) cmd = ddge_pkg::CMD_CONNECT;
        else if (w < 65) cmd = ddge_pkg::CMD_DISCONNECT;
        else if (w < 75) cmd = ddge_pkg::CMD_QUERY;
        else if (w < 83) cmd = ddge_pkg::CMD_MARK_DIRTY;
        else if (w < 86) cmd = ddge_pkg::CMD_CLR_DIRTY;
        else if (w < 88) cmd = ddge_pkg::CMD_CLEAR;
        else if (w < 92) cmd = ddge_pkg::CMD_CYCLE_CHK;
        else if (w < 99) cmd = ddge_pkg::CMD_EVALUATE;
        else             cmd = 4'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
        send_cmd(cmd, pick_id(), pick_id(), pick_id(), 4'($urandom));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty graph, edge rules, dirty propagation, cycles, full table
        send_cmd(ddge_pkg::CMD_EVALUATE,   16'd0,    16'd0, 16'd0, 4'd0);
        send_cmd(ddge_pkg::CMD_QUERY,      16'd0,    16'd0, 16'd0, 4'd0);
        send_cmd(ddge_pkg::CMD_REMOVE,     16'hFFFF, 16'd0, 16'd0, 4'd0);
        send_cmd(ddge_pkg::CMD_ADD,        16'd0,    16'd0, 16'd0, 4'd0);
        send_cmd(ddge_pkg::CMD_ADD,        16'd0,    16'd0, 16'd0, 4'hF);
        send_cmd(ddge_pkg::CMD_ADD,        16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd5);
        send_cmd(ddge_pkg::CMD_CONNECT,    16'd0,    16'd1, 16'd2, 4'd0);
        send_cmd(ddge_pkg::CMD_CONNECT,    16'd0,    16'd1, 16'd2, 4'd0);   // duplicate
        send_cmd(ddge_pkg::CMD_CONNECT,    16'd0,    16'd1, 16'd1, 4'd0);   // self-loop
        send_cmd(ddge_pkg::CMD_CONNECT,    16'd0,    16'd1, 16'hFFFF, 4'd0); // missing end
        send_cmd(ddge_pkg::CMD_DISCONNECT, 16'd0,    16'd2, 16'd1, 4'd0);   // no such edge
        send_cmd(ddge_pkg::CMD_CONNECT,    16'd0,    16'd2, 16'd3, 4'd0);
        send_cmd(ddge_pkg::CMD_QUERY,      16'd3,    16'd0, 16'd0, 4'd0);
        send_cmd(ddge_pkg::CMD_EVALUATE,   16'd0,    16'd0, 16'd0, 4'd0);
        send_cmd(ddge_pkg::CMD_MARK_DIRTY, 16'd2,    16'd0, 16'd0, 4'd0);
        send_cmd(ddge_pkg::CMD_QUERY,      16'd1,    16'd0, 16'd0, 4'd0);
        send_cmd(ddge_pkg::CMD_EVALUATE,   16'd0,    16'd0, 16'd0, 4'd0);
        send_cmd(ddge_pkg::CMD_CONNECT,    16'd0,    16'd3, 16'd1, 4'd0);   // closes a cycle
        send_cmd(ddge_pkg::CMD_CYCLE_CHK,  16'd0,    16'd0, 16'd0, 4'd0);
        send_cmd(ddge_pkg::CMD_EVALUATE,   16'd0,    16'd0, 16'd0, 4'd0);
        send_cmd(ddge_pkg::CMD_REMOVE,     16'd2,    16'd0, 16'd0, 4'd0);
        send_cmd(ddge_pkg::CMD_CYCLE_CHK,  16'd0,    16'd0, 16'd0, 4'd0);
        send_cmd(ddge_pkg::CMD_CLR_DIRTY,  16'd0,    16'd0, 16'd0, 4'd0);
        send_cmd(CMD_UNKNOWN_LO,           16'd1,    16'd1, 16'd3, 4'd0);
        send_cmd(CMD_UNKNOWN_HI,           16'd1,    16'd1, 16'd3, 4'd0);
        send_cmd(ddge_pkg::CMD_CLEAR,      16'd0,    16'd0, 16'd0, 4'd0);
        // fill every slot, then one more add must report full
        repeat (33) send_cmd(ddge_pkg::CMD_ADD, 16'd0, 16'd0, 16'd0, 4'($urandom));
        send_cmd(ddge_pkg::CMD_EVALUATE,   16'd0,    16'd0, 16'd0, 4'd0);
        send_cmd(ddge_pkg::CMD_CLEAR,      16'd0,    16'd0, 16'd0, 4'd0);

        // Random part in four idling phases
        for (int k = 0; k < RANDOM_CMDS; k++) begin
            case (k * 4 / RANDOM_CMDS)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            random_cmd();
        end
        cmd_valid <= 1'b0;

        // Drain: the watchdog bounds this wait
        while (pending != 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
